// ===== hw/rtl/ksis_pkg.sv =====
// types and constants shared by the k-smallest index select unit
package ksis_pkg;

	localparam int SCORE_W        = 32;
	localparam int INDEX_W        = 6;
	localparam int KEEP_W         = 7;
	localparam int MAX_LAYERS_DEF = 64;

	localparam logic [KEEP_W-1:0] KEEP_RESET = 7'd64;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic               last;
	} ksis_req_t;

	typedef struct packed {
		logic [INDEX_W-1:0] index;
		logic               final_res;
		logic               empty_res;
	} ksis_res_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_EMIT = 3'b100
	} ksis_state_t;

endpackage

// ===== hw/rtl/k_smallest_index_select_unit.sv =====
// top level of the k-smallest index select unit
//
// Usage: each request carries one score and a last flag; it is taken at a clock
// edge where start is high and busy is low. Scores are stored at positions
// 0, 1, 2, ... (scores past MAX_LAYERS are dropped). Loading accepts one request
// per cycle and busy stays low.
// On a request flagged last, the unit drops loaded - keep_count entries with the
// smallest scores (equal scores: lower position first) and reports their
// positions in descending order on result, one per strobe cycle, the final one
// marked with final_res. If nothing is to be dropped a single result with
// empty_res set appears in the next cycle and busy never rises.
// Otherwise busy is high while one shared compare unit walks the score ram:
// each pass reads every loaded entry once, one per cycle, and selects one
// entry; then the emit walk steps down from the highest loaded position.
// Results are shown for exactly one cycle each; the receiver cannot stall.
// the user must write keep_count (keep_count_we / keep_count_data) only while
// idle; the unit does not enforce it. Reset clears the loaded count, selection
// flags, sets keep_count to 64; score ram stays undefined until written.
module k_smallest_index_select_unit
	import ksis_pkg::*;
#(
	parameter int MAX_LAYERS = MAX_LAYERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ksis_req_t         request,
	input  logic              keep_count_we,
	input  logic [KEEP_W-1:0] keep_count_data,
	output logic              strobe,
	output ksis_res_t         result
);

	localparam int AW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
	localparam int CW = $clog2(MAX_LAYERS + 1);
	localparam int XW = (CW > KEEP_W) ? CW : KEEP_W;

	ksis_state_t        state_q;
	logic [KEEP_W-1:0]  keep_q;
	logic [CW-1:0]      loaded_q;
	logic [MAX_LAYERS-1:0] mask_q;
	logic [CW-1:0]      drop_q;
	logic [CW-1:0]      pass_q;
	logic [CW-1:0]      rem_q;
	logic [AW-1:0]      rd_q;
	logic               iss_q;
	logic               vld_s1;
	logic [AW-1:0]      idx_s1;
	logic               found_q;
	logic [SCORE_W-1:0] min_q;
	logic [AW-1:0]      pick_q;
	logic [AW-1:0]      emit_q;
	logic               strobe_q;
	ksis_res_t          res_q;

	logic               accept;
	logic               room;
	logic [CW-1:0]      n_next;
	logic [XW-1:0]      n_x;
	logic [XW-1:0]      k_x;
	logic [CW-1:0]      drop_w;
	logic [CW-1:0]      lidx_w;
	logic [AW-1:0]      lidx;
	logic [SCORE_W-1:0] rdata;
	logic               cand;
	logic [AW-1:0]      pick_w;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);
	assign room   = (loaded_q < CW'(MAX_LAYERS));
	assign n_next = room ? loaded_q + CW'(1) : loaded_q;
	assign n_x    = XW'(n_next);
	assign k_x    = XW'(keep_q);
	assign drop_w = (k_x < n_x) ? CW'(n_x - k_x) : '0;
	assign lidx_w = loaded_q - CW'(1);
	assign lidx   = lidx_w[AW-1:0];

	ksis_ram #(
		.WIDTH(SCORE_W),
		.DEPTH(MAX_LAYERS)
	) u_store (
		.clk  (clk),
		.we   (accept && room),
		.waddr(loaded_q[AW-1:0]),
		.wdata(request.score),
		.raddr(rd_q),
		.rdata(rdata)
	);

	// shared compare: unselected entry that beats the running minimum
	assign cand   = vld_s1 && !mask_q[idx_s1] && (!found_q || (rdata < min_q));
	assign pick_w = cand ? idx_s1 : pick_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			keep_q   <= KEEP_RESET;
			loaded_q <= '0;
			mask_q   <= '0;
			drop_q   <= '0;
			pass_q   <= '0;
			rem_q    <= '0;
			rd_q     <= '0;
			iss_q    <= 1'b0;
			vld_s1   <= 1'b0;
			idx_s1   <= '0;
			found_q  <= 1'b0;
			min_q    <= '0;
			pick_q   <= '0;
			emit_q   <= '0;
			strobe_q <= 1'b0;
			res_q    <= '0;
		end else begin
			strobe_q <= 1'b0;
			if (keep_count_we) begin
				keep_q <= keep_count_data;
			end
			unique case (state_q)
				ST_IDLE: begin
					vld_s1 <= 1'b0;
					if (accept) begin
						loaded_q <= n_next;
						if (request.last) begin
							mask_q <= '0;
							if (drop_w == '0) begin
								strobe_q        <= 1'b1;
								res_q.index     <= '0;
								res_q.final_res <= 1'b1;
								res_q.empty_res <= 1'b1;
								loaded_q        <= '0;
							end else begin
								state_q <= ST_SCAN;
								drop_q  <= drop_w;
								pass_q  <= '0;
								rd_q    <= '0;
								iss_q   <= 1'b1;
								found_q <= 1'b0;
							end
						end
					end
				end
				ST_SCAN: begin
					// address issue side
					vld_s1 <= iss_q;
					idx_s1 <= rd_q;
					if (iss_q) begin
						if (rd_q == lidx) begin
							iss_q <= 1'b0;
						end else begin
							rd_q <= rd_q + AW'(1);
						end
					end
					// compare side, one entry per cycle
					if (vld_s1) begin
						if (idx_s1 == lidx) begin
							mask_q[pick_w] <= 1'b1;
							found_q        <= 1'b0;
							pass_q         <= pass_q + CW'(1);
							if (pass_q + CW'(1) == drop_q) begin
								state_q <= ST_EMIT;
								emit_q  <= lidx;
								rem_q   <= drop_q;
							end else begin
								rd_q  <= '0;
								iss_q <= 1'b1;
							end
						end else if (cand) begin
							found_q <= 1'b1;
							min_q   <= rdata;
							pick_q  <= idx_s1;
						end
					end
				end
				ST_EMIT: begin
					vld_s1 <= 1'b0;
					if (mask_q[emit_q]) begin
						strobe_q        <= 1'b1;
						res_q.index     <= INDEX_W'(emit_q);
						res_q.final_res <= (rem_q == CW'(1));
						res_q.empty_res <= 1'b0;
						rem_q           <= rem_q - CW'(1);
					end
					if (mask_q[emit_q] && (rem_q == CW'(1))) begin
						state_q  <= ST_IDLE;
						mask_q   <= '0;
						loaded_q <= '0;
					end else begin
						emit_q <= emit_q - AW'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign strobe = strobe_q;
	assign result = res_q;

endmodule

// ===== hw/rtl/ksis_ram.sv =====
// generic single write port, single read port ram with registered read data
module ksis_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
